>>> rtl/radio_connection_setup_controller_core_macros.svh
// Assertion macros for the radio connection set-up controller.
`ifndef RADIO_CONNECTION_SETUP_CONTROLLER_CORE_MACROS_SVH
`define RADIO_CONNECTION_SETUP_CONTROLLER_CORE_MACROS_SVH

// Same-cycle implication, checked on every rising clock edge out of reset.
`define RCSC_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("rcsc: same-cycle check failed");

// Next-cycle implication.
`define RCSC_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("rcsc: next-cycle check failed");

`endif

>>> rtl/rcsc_pkg.sv
// Package: types, codes and constants of the radio connection set-up controller.
package rcsc_pkg;

  localparam int unsigned TIMER_WIDTH_DEF = 16;
  localparam int unsigned CFG_WAIT_W      = 16;
  localparam int unsigned LOSS_W          = CFG_WAIT_W + 1;
  localparam int unsigned ATT_W           = 4;
  localparam int unsigned VER_W           = 7;
  localparam int unsigned MTYPE_W         = 3;
  localparam int unsigned CFG_IDX_W       = 3;
  localparam int unsigned CFG_DATA_W      = 16;
  localparam int unsigned S_TDATA_W       = 16;
  localparam int unsigned M_TDATA_W       = 8;

  // Register indexes of the configuration port
  localparam logic [CFG_IDX_W-1:0] REG_EXPECTED_VERSION = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TRACKSIDE_WAIT   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ATTEMPT_WAIT     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_ATTEMPTS     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_LOSS_WINDOW      = 3'd4;

  // Trackside message type that carries the system version
  localparam logic [MTYPE_W-1:0] MSG_SYS_VERSION = 3'd1;

  typedef enum logic [1:0] {
    KIND_TICK  = 2'd0,
    KIND_ORDER = 2'd1,
    KIND_RADIO = 2'd2,
    KIND_MSG   = 2'd3
  } kind_e;

  typedef enum logic [1:0] {
    PH_IDLE  = 2'd0,
    PH_SETUP = 2'd1,
    PH_WAIT  = 2'd2,
    PH_SUSP  = 2'd3
  } phase_e;

  typedef enum logic [1:0] {
    SEND_INIT        = 2'd0,
    SEND_ESTABLISHED = 2'd1,
    SEND_INCOMPAT    = 2'd2
  } send_e;

  typedef enum logic [2:0] {
    NOTE_NONE      = 3'd0,
    NOTE_IGNORED   = 3'd1,
    NOTE_RADIO_FAIL = 3'd2,
    NOTE_TIMEOUT   = 3'd3,
    NOTE_WRONG_MSG = 3'd4,
    NOTE_WRONG_VER = 3'd5,
    NOTE_LOST      = 3'd6,
    NOTE_TERMINATE = 3'd7
  } notify_e;

  typedef struct packed {
    logic [VER_W-1:0]      expected_version;
    logic [CFG_WAIT_W-1:0] trackside_wait_s;
    logic [CFG_WAIT_W-1:0] attempt_wait_s;
    logic [ATT_W-1:0]      max_attempts;
    logic [CFG_WAIT_W-1:0] loss_window_s;
  } cfg_t;

  typedef struct packed {
    kind_e               kind;
    logic                order_value;
    logic                radio_up;
    logic [MTYPE_W-1:0]  msg_type;
    logic [VER_W-1:0]    msg_version;
  } item_t;

  typedef struct packed {
    logic    conn_status;
    logic    radio_request;
    logic    send_valid;
    send_e   send_type;
    notify_e notify;
  } result_t;

endpackage

>>> rtl/rcsc_cfg_regs.sv
// Configuration register file of the radio connection set-up controller.
module rcsc_cfg_regs
  import rcsc_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  output cfg_t                  cfg_o
);

  cfg_t cfg_q, cfg_d;

  assign cfg_ready_o = 1'b1;
  assign cfg_o       = cfg_q;

  // Decode the write; unknown indexes leave everything as is
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      unique case (cfg_index_i)
        REG_EXPECTED_VERSION: cfg_d.expected_version = cfg_data_i[VER_W-1:0];
        REG_TRACKSIDE_WAIT:   cfg_d.trackside_wait_s = cfg_data_i[CFG_WAIT_W-1:0];
        REG_ATTEMPT_WAIT:     cfg_d.attempt_wait_s   = cfg_data_i[CFG_WAIT_W-1:0];
        REG_MAX_ATTEMPTS:     cfg_d.max_attempts     = cfg_data_i[ATT_W-1:0];
        REG_LOSS_WINDOW:      cfg_d.loss_window_s    = cfg_data_i[CFG_WAIT_W-1:0];
        default:              cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.expected_version <= VER_W'(1);
      cfg_q.trackside_wait_s <= CFG_WAIT_W'(30);
      cfg_q.attempt_wait_s   <= CFG_WAIT_W'(40);
      cfg_q.max_attempts     <= ATT_W'(3);
      cfg_q.loss_window_s    <= CFG_WAIT_W'(300);
    end else begin
      cfg_q <= cfg_d;
    end
  end

endmodule

>>> rtl/rcsc_ctrl.sv
// Connection set-up state machine: state registers and one-pass step logic.
module rcsc_ctrl
  import rcsc_pkg::*;
#(
  parameter int unsigned TIMER_WIDTH = TIMER_WIDTH_DEF
) (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    step_i,
  input  item_t   item_i,
  input  cfg_t    cfg_i,
  output result_t res_o
);

  localparam int unsigned TW = TIMER_WIDTH;

  phase_e            phase_q, phase_d;
  logic [ATT_W-1:0]  att_cnt_q, att_cnt_d;
  logic [TW-1:0]     att_tmr_q, att_tmr_d;
  logic [TW-1:0]     reply_q, reply_d;
  logic [TW-1:0]     susp_q, susp_d;
  logic              conn_q, conn_d;
  logic              radio_q, radio_d;
  logic [LOSS_W-1:0] loss_q, loss_d;

  logic              req, snd;
  send_e             typ;
  notify_e           note;

  logic [ATT_W-1:0]  max_att;
  logic              att_exp, reply_exp, susp_exp;
  logic [TW-1:0]     att_dec, reply_dec, susp_dec;
  logic [LOSS_W-1:0] loss_dec;
  logic [TW-1:0]     loss_win;

  // Timer decrements; a timer at zero or one expires on the tick
  always_comb begin
    att_exp   = (att_tmr_q <= TW'(1));
    reply_exp = (reply_q <= TW'(1));
    susp_exp  = (susp_q <= TW'(1));
    att_dec   = att_exp ? '0 : att_tmr_q - TW'(1);
    reply_dec = reply_exp ? '0 : reply_q - TW'(1);
    susp_dec  = susp_exp ? '0 : susp_q - TW'(1);
    loss_dec  = loss_q - LOSS_W'(1);
    max_att   = (cfg_i.max_attempts == '0) ? ATT_W'(1) : cfg_i.max_attempts;
    loss_win  = TW'(cfg_i.loss_window_s);
  end

  // Next state and result for the item in the input register
  always_comb begin
    phase_d   = phase_q;
    att_cnt_d = att_cnt_q;
    att_tmr_d = att_tmr_q;
    reply_d   = reply_q;
    susp_d    = susp_q;
    conn_d    = conn_q;
    radio_d   = radio_q;
    loss_d    = loss_q;
    req       = 1'b0;
    snd       = 1'b0;
    typ       = SEND_INIT;
    note      = NOTE_NONE;

    unique case (item_i.kind)
      KIND_TICK: begin
        // loss watchdog
        if (loss_q != '0) begin
          if (loss_dec <= LOSS_W'(1)) begin
            loss_d = '0;
            if (conn_q) begin
              conn_d = 1'b0;
              note   = NOTE_LOST;
            end
          end else begin
            loss_d = loss_dec;
          end
        end
        unique case (phase_q)
          PH_SETUP: begin
            att_tmr_d = att_dec;
            if (att_exp) begin
              if (att_cnt_q >= max_att) begin
                note      = NOTE_RADIO_FAIL;
                att_cnt_d = '0;
                phase_d   = PH_IDLE;
              end else begin
                req       = 1'b1;
                att_cnt_d = att_cnt_q + ATT_W'(1);
                att_tmr_d = TW'(cfg_i.attempt_wait_s);
              end
            end
          end
          PH_WAIT: begin
            reply_d = reply_dec;
            if (reply_exp) begin
              note    = NOTE_TIMEOUT;
              phase_d = PH_IDLE;
            end
          end
          PH_SUSP: begin
            reply_d = reply_dec;
            susp_d  = susp_dec;
            if (susp_exp) begin
              note    = NOTE_RADIO_FAIL;
              reply_d = '0;
              phase_d = PH_IDLE;
            end
          end
          PH_IDLE: begin
          end
        endcase
      end

      KIND_ORDER: begin
        priority if (phase_q != PH_IDLE) begin
          note = NOTE_IGNORED;
        end else if (!item_i.order_value) begin
          note = NOTE_TERMINATE;
        end else if (conn_q) begin
          note = NOTE_IGNORED;
        end else if (radio_q) begin
          // radio already up: send init and wait for the version
          snd       = 1'b1;
          typ       = SEND_INIT;
          reply_d   = TW'(cfg_i.trackside_wait_s);
          att_cnt_d = '0;
          att_tmr_d = '0;
          phase_d   = PH_WAIT;
        end else begin
          req       = 1'b1;
          att_cnt_d = ATT_W'(1);
          att_tmr_d = TW'(cfg_i.attempt_wait_s);
          phase_d   = PH_SETUP;
        end
      end

      KIND_RADIO: begin
        if (item_i.radio_up != radio_q) begin
          radio_d = item_i.radio_up;
          if (!item_i.radio_up) begin
            loss_d = LOSS_W'(cfg_i.loss_window_s) + LOSS_W'(1);
            if (phase_q == PH_WAIT) begin
              susp_d  = (loss_win < reply_q) ? loss_win : reply_q;
              phase_d = PH_SUSP;
            end
          end else begin
            loss_d = '0;
            if (phase_q == PH_SETUP) begin
              snd       = 1'b1;
              typ       = SEND_INIT;
              reply_d   = TW'(cfg_i.trackside_wait_s);
              att_cnt_d = '0;
              att_tmr_d = '0;
              phase_d   = PH_WAIT;
            end else if (phase_q == PH_SUSP) begin
              susp_d  = '0;
              phase_d = PH_WAIT;
            end
          end
        end
      end

      KIND_MSG: begin
        if (phase_q == PH_WAIT) begin
          priority if (item_i.msg_type != MSG_SYS_VERSION) begin
            note = NOTE_WRONG_MSG;
          end else if (item_i.msg_version != cfg_i.expected_version) begin
            snd  = 1'b1;
            typ  = SEND_INCOMPAT;
            note = NOTE_WRONG_VER;
          end else begin
            snd    = 1'b1;
            typ    = SEND_ESTABLISHED;
            conn_d = 1'b1;
          end
          reply_d = '0;
          phase_d = PH_IDLE;
        end
      end
    endcase

    res_o.conn_status   = conn_d;
    res_o.radio_request = req;
    res_o.send_valid    = snd;
    res_o.send_type     = typ;
    res_o.notify        = note;
  end

  // State registers, updated once per processed item
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= PH_IDLE;
      att_cnt_q <= '0;
      att_tmr_q <= '0;
      reply_q   <= '0;
      susp_q    <= '0;
      conn_q    <= 1'b0;
      radio_q   <= 1'b0;
      loss_q    <= '0;
    end else if (step_i) begin
      phase_q   <= phase_d;
      att_cnt_q <= att_cnt_d;
      att_tmr_q <= att_tmr_d;
      reply_q   <= reply_d;
      susp_q    <= susp_d;
      conn_q    <= conn_d;
      radio_q   <= radio_d;
      loss_q    <= loss_d;
    end
  end

endmodule

>>> rtl/radio_connection_setup_controller_core.sv
// Top level of the radio connection set-up controller: stream ports and item stages.
//
// Usage:
//   Input stream s_axis_*: one beat per event. tuser carries the kind (second tick,
//   connection order, radio status, trackside message); tdata carries the event
//   fields. Output stream m_axis_*: exactly one result beat per input beat, in order.
//   Configuration port cfg_*: one register write per beat, always ready; write only
//   while no beats are in flight.
//   Path: an accepted beat waits in the input register, is processed when the output
//   register is free or being drained, and its result is registered in the output
//   register, from which it shows on m_axis.
//   Throughput: one beat per cycle while m_axis_tready stays high, set by the single
//   step of the state machine between the input register and the output register.
//   Stall: when m_axis_tready is low the result holds; one more beat waits in the
//   input register, then s_axis_tready drops until the output drains.
//   Reset: rst_ni clears both stages, the connection state (idle, not connected,
//   radio down, watchdog inactive) and loads the register defaults.
`include "radio_connection_setup_controller_core_macros.svh"

module radio_connection_setup_controller_core
  import rcsc_pkg::*;
#(
  parameter int unsigned TIMER_WIDTH = TIMER_WIDTH_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // input stream
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [S_TDATA_W-1:0]  s_axis_tdata,  // order_value, radio_up, msg_type[2:0],
                                               // msg_version[6:0], zero pad
  input  logic [1:0]            s_axis_tuser,  // kind[1:0]
  // result stream
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  output logic [M_TDATA_W-1:0]  m_axis_tdata,  // conn_status, radio_request, send_valid,
                                               // send_type[1:0], notify[2:0]
  // configuration writes
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  cfg_t    cfg;
  item_t   in_q;
  item_t   in_beat;
  logic    in_vld_q, in_vld_d;
  result_t res;
  result_t out_q;
  logic    out_vld_q, out_vld_d;
  logic    s_accept, adv;

  rcsc_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  rcsc_ctrl #(
    .TIMER_WIDTH (TIMER_WIDTH)
  ) u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (adv),
    .item_i (in_q),
    .cfg_i  (cfg),
    .res_o  (res)
  );

  // Unpack the input beat
  always_comb begin
    in_beat.kind        = kind_e'(s_axis_tuser[1:0]);
    in_beat.order_value = s_axis_tdata[0];
    in_beat.radio_up    = s_axis_tdata[1];
    in_beat.msg_type    = s_axis_tdata[4:2];
    in_beat.msg_version = s_axis_tdata[11:5];
  end

  // Handshake: step when an item waits and the output slot is free or draining
  assign adv           = in_vld_q && (!out_vld_q || m_axis_tready);
  assign s_axis_tready = !in_vld_q || adv;
  assign s_accept      = s_axis_tvalid && s_axis_tready;
  assign in_vld_d      = s_accept || (in_vld_q && !adv);
  assign out_vld_d     = adv || (out_vld_q && !m_axis_tready);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      in_vld_q  <= in_vld_d;
      out_vld_q <= out_vld_d;
    end
  end

  // Payload stages
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_q  <= '0;
      out_q <= '0;
    end else begin
      if (s_accept) begin
        in_q <= in_beat;
      end
      if (adv) begin
        out_q <= res;
      end
    end
  end

  // Pack the result beat
  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = {out_q.notify, out_q.send_type, out_q.send_valid,
                          out_q.radio_request, out_q.conn_status};

  // Checks
  `RCSC_ASSERT_IMPL(a_send_type_idle, out_vld_q && !out_q.send_valid,
                    out_q.send_type == SEND_INIT)
  `RCSC_ASSERT_IMPL(a_req_xor_send, out_vld_q,
                    !(out_q.radio_request && out_q.send_valid))
  `RCSC_ASSERT_IMPL(a_full_blocks_input, in_vld_q && out_vld_q && !m_axis_tready,
                    !s_axis_tready)
  `RCSC_ASSERT_NEXT(a_step_fills_output, adv, out_vld_q)

endmodule

>>> tb/tb_radio_connection_setup_controller_core.sv
// Testbench for the radio connection set-up controller: random and directed events checked against a predictor.
module tb_radio_connection_setup_controller_core;
  import rcsc_pkg::*;

  // Predicts the result beat of each event and checks the beats that come out
  class setup_outcome_board;
    // register shadow
    logic [VER_W-1:0]      want_version;
    logic [CFG_WAIT_W-1:0] reply_wait;
    logic [CFG_WAIT_W-1:0] attempt_wait;
    logic [ATT_W-1:0]      attempts_max;
    logic [CFG_WAIT_W-1:0] loss_window;
    // connection state
    phase_e                phase;
    logic [ATT_W-1:0]      attempt_no;
    logic [CFG_WAIT_W-1:0] attempt_left;
    logic [CFG_WAIT_W-1:0] reply_left;
    logic [CFG_WAIT_W-1:0] suspend_left;
    logic                  linked;
    logic                  radio_ok;
    logic [LOSS_W-1:0]     loss_left;

    result_t     due_outcomes[$];
    int unsigned errors;
    int unsigned events;

    function new();
      want_version = 7'd1;
      reply_wait   = 16'd30;
      attempt_wait = 16'd40;
      attempts_max = 4'd3;
      loss_window  = 16'd300;
      phase        = PH_IDLE;
      attempt_no   = '0;
      attempt_left = '0;
      reply_left   = '0;
      suspend_left = '0;
      linked       = 1'b0;
      radio_ok     = 1'b0;
      loss_left    = '0;
      errors       = 0;
      events       = 0;
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
      case (idx)
        REG_EXPECTED_VERSION: want_version = val[VER_W-1:0];
        REG_TRACKSIDE_WAIT:   reply_wait   = val;
        REG_ATTEMPT_WAIT:     attempt_wait = val;
        REG_MAX_ATTEMPTS:     attempts_max = val[ATT_W-1:0];
        REG_LOSS_WINDOW:      loss_window  = val;
        default: ;
      endcase
    endfunction

    // One-second countdown; 0 or 1 expires on this tick
    function bit count_down(inout logic [CFG_WAIT_W-1:0] t);
      if (t <= 1) begin
        t = '0;
        return 1'b1;
      end
      t = t - 1'b1;
      return 1'b0;
    endfunction

    function void open_reply_wait();
      reply_left   = reply_wait;
      attempt_no   = '0;
      attempt_left = '0;
      phase        = PH_WAIT;
    endfunction

    // Step the predictor by one accepted event and queue its outcome
    function void note_event(item_t it);
      result_t          r;
      logic [ATT_W-1:0] cap;
      r.conn_status   = 1'b0;
      r.radio_request = 1'b0;
      r.send_valid    = 1'b0;
      r.send_type     = SEND_INIT;
      r.notify        = NOTE_NONE;
      cap = (attempts_max == 0) ? 4'd1 : attempts_max;
      events++;
      case (it.kind)
        KIND_TICK: begin
          // loss watchdog first, set-up phase may override the note
          if (loss_left != 0) begin
            loss_left = loss_left - 1'b1;
            if (loss_left <= 1) begin
              loss_left = '0;
              if (linked) begin
                linked   = 1'b0;
                r.notify = NOTE_LOST;
              end
            end
          end
          case (phase)
            PH_SETUP: begin
              if (count_down(attempt_left)) begin
                if (attempt_no >= cap) begin
                  r.notify   = NOTE_RADIO_FAIL;
                  attempt_no = '0;
                  phase      = PH_IDLE;
                end else begin
                  r.radio_request = 1'b1;
                  attempt_no      = attempt_no + 1'b1;
                  attempt_left    = attempt_wait;
                end
              end
            end
            PH_WAIT: begin
              if (count_down(reply_left)) begin
                r.notify = NOTE_TIMEOUT;
                phase    = PH_IDLE;
              end
            end
            PH_SUSP: begin
              void'(count_down(reply_left));
              if (count_down(suspend_left)) begin
                r.notify   = NOTE_RADIO_FAIL;
                reply_left = '0;
                phase      = PH_IDLE;
              end
            end
            default: ;
          endcase
        end
        KIND_ORDER: begin
          if (phase != PH_IDLE) begin
            r.notify = NOTE_IGNORED;
          end else if (!it.order_value) begin
            r.notify = NOTE_TERMINATE;
          end else if (linked) begin
            r.notify = NOTE_IGNORED;
          end else if (radio_ok) begin
            r.send_valid = 1'b1;
            r.send_type  = SEND_INIT;
            open_reply_wait();
          end else begin
            r.radio_request = 1'b1;
            attempt_no      = 4'd1;
            attempt_left    = attempt_wait;
            phase           = PH_SETUP;
          end
        end
        KIND_RADIO: begin
          if (it.radio_up != radio_ok) begin
            radio_ok = it.radio_up;
            if (!it.radio_up) begin
              loss_left = {1'b0, loss_window} + 1'b1;
              if (phase == PH_WAIT) begin
                suspend_left = (loss_window < reply_left) ? loss_window : reply_left;
                phase        = PH_SUSP;
              end
            end else begin
              loss_left = '0;
              if (phase == PH_SETUP) begin
                r.send_valid = 1'b1;
                r.send_type  = SEND_INIT;
                open_reply_wait();
              end else if (phase == PH_SUSP) begin
                suspend_left = '0;
                phase        = PH_WAIT;
              end
            end
          end
        end
        default: begin
          // trackside message only counts while waiting for the reply
          if (phase == PH_WAIT) begin
            if (it.msg_type != MSG_SYS_VERSION) begin
              r.notify = NOTE_WRONG_MSG;
            end else if (it.msg_version != want_version) begin
              r.send_valid = 1'b1;
              r.send_type  = SEND_INCOMPAT;
              r.notify     = NOTE_WRONG_VER;
            end else begin
              r.send_valid = 1'b1;
              r.send_type  = SEND_ESTABLISHED;
              linked       = 1'b1;
            end
            reply_left = '0;
            phase      = PH_IDLE;
          end
        end
      endcase
      r.conn_status = linked;
      due_outcomes.push_back(r);
    endfunction

    function void compare_field(string name, logic [2:0] want, logic [2:0] got);
      if (got !== want) begin
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
        errors++;
      end
    endfunction

    // Compare one result beat with the oldest outcome due
    function void check_outcome(logic [M_TDATA_W-1:0] d);
      result_t want;
      if (due_outcomes.size() == 0) begin
        $display("%0t: result beat %h with no outcome due, expected none, actual %h",
                 $time, d, d);
        errors++;
        return;
      end
      want = due_outcomes.pop_front();
      compare_field("conn_status", {2'b0, want.conn_status}, {2'b0, d[0]});
      compare_field("radio_request", {2'b0, want.radio_request}, {2'b0, d[1]});
      compare_field("send_valid", {2'b0, want.send_valid}, {2'b0, d[2]});
      compare_field("send_type", {1'b0, want.send_type}, {1'b0, d[4:3]});
      compare_field("notify", want.notify, d[7:5]);
    endfunction
  endclass

  logic                  clk_i;
  logic                  rst_ni;
  logic                  s_axis_tvalid;
  logic                  s_axis_tready;
  logic [S_TDATA_W-1:0]  s_axis_tdata;
  logic [1:0]            s_axis_tuser;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready;
  logic [M_TDATA_W-1:0]  m_axis_tdata;
  logic                  cfg_valid_i;
  logic                  cfg_ready_o;
  logic [CFG_IDX_W-1:0]  cfg_index_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;

  setup_outcome_board board;
  int unsigned send_idle_pct  = 0;
  int unsigned recv_stall_pct = 0;
  bit          hold_req       = 1'b0;
  int unsigned hold_left      = 0;

  radio_connection_setup_controller_core dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // Run limit
  initial begin
    #8000000;
    $display("tb_radio_connection_setup_controller_core: errors");
    $finish;
  end

  // Result side: check accepted beats, stall at random or for a long hold-off
  initial begin
    m_axis_tready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && m_axis_tvalid && m_axis_tready) board.check_outcome(m_axis_tdata);
      if (hold_req) begin
        hold_left = 300;
        hold_req  = 1'b0;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  // Event with every field random, kind fixed
  function automatic item_t blank_event(kind_e k);
    item_t it;
    it.kind        = k;
    it.order_value = 1'($urandom_range(1));
    it.radio_up    = 1'($urandom_range(1));
    it.msg_type    = 3'($urandom_range(7));
    it.msg_version = 7'($urandom_range(127));
    return it;
  endfunction

  // Offer one event beat, with an optional random gap ahead of it
  task automatic push_event(item_t it);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {4'b0, it.msg_version, it.msg_type, it.radio_up, it.order_value};
    s_axis_tuser  <= it.kind;
    do @(posedge clk_i); while (!s_axis_tready);
    board.note_event(it);
  endtask

  task automatic push_tick();
    push_event(blank_event(KIND_TICK));
  endtask

  task automatic push_order(bit connect);
    item_t it;
    it = blank_event(KIND_ORDER);
    it.order_value = connect;
    push_event(it);
  endtask

  task automatic push_radio(bit up);
    item_t it;
    it = blank_event(KIND_RADIO);
    it.radio_up = up;
    push_event(it);
  endtask

  task automatic push_msg(logic [MTYPE_W-1:0] mtype, logic [VER_W-1:0] ver);
    item_t it;
    it = blank_event(KIND_MSG);
    it.msg_type    = mtype;
    it.msg_version = ver;
    push_event(it);
  endtask

  task automatic push_noise();
    push_event(blank_event(kind_e'($urandom_range(3))));
  endtask

  // Register write; the caller lowers valid after its last write
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    board.set_reg(idx, val);
  endtask

  // Unused upper data bits get random values
  task automatic load_regs(logic [VER_W-1:0] ver, logic [CFG_WAIT_W-1:0] reply_s,
                           logic [CFG_WAIT_W-1:0] attempt_s, logic [ATT_W-1:0] tries,
                           logic [CFG_WAIT_W-1:0] loss_s);
    write_reg(REG_EXPECTED_VERSION, {9'($urandom), ver});
    write_reg(REG_TRACKSIDE_WAIT, reply_s);
    write_reg(REG_ATTEMPT_WAIT, attempt_s);
    write_reg(REG_MAX_ATTEMPTS, {12'($urandom), tries});
    write_reg(REG_LOSS_WINDOW, loss_s);
    cfg_valid_i <= 1'b0;
  endtask

  // Small waits, the reply and attempt waits now and then zero
  task automatic load_small_regs();
    load_regs(7'($urandom_range(127)),
              ($urandom_range(9) == 0) ? 16'd0 : 16'($urandom_range(1, 6)),
              ($urandom_range(9) == 0) ? 16'd0 : 16'($urandom_range(1, 5)),
              4'($urandom_range(0, 4)),
              16'($urandom_range(1, 8)));
  endtask

  // Let every outstanding result come back, then let the bench settle
  task automatic drain();
    while (board.due_outcomes.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // One connection attempt with random timing, radio events and reply
  task automatic run_session();
    int unsigned span;
    int unsigned n;
    if ($urandom_range(99) < 30) push_noise();
    push_order($urandom_range(99) < 90);
    if (!board.radio_ok) begin
      span = ((board.attempt_wait == 0) ? 1 : board.attempt_wait)
             * ((board.attempts_max == 0) ? 1 : board.attempts_max) + 1;
      if (span > 30) span = 30;
      n = $urandom_range(0, span);
      repeat (n) push_tick();
      if ($urandom_range(99) < 80) push_radio(1'b1);
    end
    n = $urandom_range(0, 3);
    repeat (n) push_tick();
    if ($urandom_range(99) < 25) begin
      push_radio(1'b0);
      n = $urandom_range(0, 3);
      repeat (n) push_tick();
      if ($urandom_range(99) < 70) push_radio(1'b1);
    end
    push_msg(($urandom_range(99) < 80) ? MSG_SYS_VERSION : 3'($urandom_range(7)),
             ($urandom_range(99) < 60) ? board.want_version : 7'($urandom_range(127)));
    // radio loss long enough to trip the watchdog at times
    if ($urandom_range(99) < 30) begin
      span = board.loss_window + 2;
      if (span > 20) span = 20;
      push_radio(1'b0);
      n = $urandom_range(0, span);
      repeat (n) push_tick();
      if ($urandom_range(99) < 60) push_radio(1'b1);
    end
  endtask

  task automatic run_phase(int unsigned n_events, int unsigned s_pct, int unsigned r_pct,
                           bit hold);
    int unsigned goal;
    send_idle_pct  = s_pct;
    recv_stall_pct = r_pct;
    goal = board.events + n_events;
    if (hold) hold_req = 1'b1;
    while (board.events < goal) begin
      if ($urandom_range(99) < 75) run_session();
      else push_noise();
    end
    s_axis_tvalid <= 1'b0;
    drain();
  endtask

  initial begin
    int unsigned waited;
    board = new();
    rst_ni        <= 1'b0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    s_axis_tuser  <= KIND_TICK;
    cfg_valid_i   <= 1'b0;
    cfg_index_i   <= REG_EXPECTED_VERSION;
    cfg_data_i    <= '0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Register defaults: set-up, init and a wrong version
    push_order(1'b1);
    push_msg(MSG_SYS_VERSION, 7'd1);
    push_radio(1'b1);
    push_msg(MSG_SYS_VERSION, 7'd2);
    s_axis_tvalid <= 1'b0;
    drain();

    // Directed: zero attempt wait and zero attempts act as one
    load_regs(7'd127, 16'd2, 16'd0, 4'd0, 16'd3);
    push_radio(1'b0);
    push_order(1'b0);                    // terminate while idle
    push_order(1'b1);                    // radio down: request
    push_order(1'b1);                    // busy
    push_tick();                         // only attempt fails
    push_order(1'b1);
    push_radio(1'b1);                    // up during set-up: init
    push_msg(3'd7, 7'd127);              // wrong message type
    push_order(1'b1);
    push_msg(MSG_SYS_VERSION, 7'd0);     // wrong version
    push_order(1'b1);
    push_tick();
    push_tick();                         // reply timeout
    push_order(1'b1);
    push_radio(1'b0);                    // suspend the wait
    push_msg(MSG_SYS_VERSION, 7'd127);   // ignored while suspended
    push_radio(1'b0);                    // same status, no change
    push_radio(1'b1);                    // resume
    push_msg(MSG_SYS_VERSION, 7'd127);   // established
    push_order(1'b1);                    // already connected
    push_order(1'b0);                    // terminate keeps the flag
    push_radio(1'b0);
    repeat (3) push_tick();              // watchdog drops the link
    push_order(1'b1);
    push_radio(1'b1);
    push_radio(1'b0);
    push_tick();
    push_tick();                         // suspension runs out
    s_axis_tvalid <= 1'b0;
    drain();

    // Random phases across idling patterns and register settings
    load_small_regs();
    run_phase(200, 0, 0, 1'b0);
    load_small_regs();
    run_phase(200, 66, 0, 1'b0);
    load_small_regs();
    run_phase(200, 0, 66, 1'b0);
    load_small_regs();
    run_phase(200, 30, 30, 1'b0);
    load_regs(7'd0, 16'hFFFF, 16'hFFFF, 4'd15, 16'hFFFF);
    run_phase(60, 30, 30, 1'b0);
    load_regs(7'd127, 16'd1, 16'd1, 4'd1, 16'd1);
    run_phase(120, 0, 0, 1'b0);
    load_small_regs();
    run_phase(80, 0, 0, 1'b1);

    // Final wait for stragglers
    waited = 0;
    while (board.due_outcomes.size() != 0 && waited < 2000) begin
      @(posedge clk_i);
      waited++;
    end
    repeat (6) @(posedge clk_i);
    if (board.due_outcomes.size() != 0) begin
      $display("%0t: outcomes still due, expected 0, actual %0d", $time,
               board.due_outcomes.size());
      board.errors++;
    end
    if (board.errors == 0) begin
      $display("tb_radio_connection_setup_controller_core: clean");
    end else begin
      $display("tb_radio_connection_setup_controller_core: errors");
    end
    $finish;
  end

endmodule

>>> radio_connection_setup_controller_core.f
+incdir+rtl
rtl/rcsc_pkg.sv
rtl/rcsc_cfg_regs.sv
rtl/rcsc_ctrl.sv
rtl/radio_connection_setup_controller_core.sv
tb/tb_radio_connection_setup_controller_core.sv
